>>> sv/ppg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppg_pkg
// Constants, stage types and the sine table for the plasma pattern generator.
// ----------------------------------------------------------------------------
package ppg_pkg;

  // Coordinate and table sizing.
  localparam int CoordBits    = 12;
  localparam int SineIdxBits  = 10;
  localparam int TblSize      = 1 << SineIdxBits;
  localparam int Qtr          = TblSize >> 2;

  // Stream widths, packed to whole bytes.
  localparam int InDataW      = ((2 * CoordBits) + 7) / 8 * 8;
  localparam int OutDataW     = 32;

  // Radius datapath: isqrt((x*x + y*y) * 256).
  localparam int SqW          = 2 * CoordBits;
  localparam int SumW         = SqW + 1;
  localparam int RootW        = (SumW + 8 + 1) / 2;
  localparam int RadW         = 2 * RootW;
  localparam int RemW         = RootW + 2;
  localparam int SqStages     = (RootW + 1) / 2;

  // Angle scale factors, round(2^32 / (2*pi*d)).
  localparam int KW           = 28;
  localparam logic [KW-1:0] KX  = KW'(97652182);
  localparam logic [KW-1:0] KY  = KW'(136713055);
  localparam logic [KW-1:0] KXY = KW'(113927546);
  localparam logic [KW-1:0] KR  = KW'(170891319);
  localparam int MulW         = CoordBits + 1 + KW;
  localparam int MulRW        = RootW + KW;

  localparam logic [15:0] PhaseStepReset = 16'd1252;
  localparam logic [7:0]  AlphaOpaque    = 8'd255;

  // Taylor series constants.
  localparam logic [63:0] PiQ30  = 64'd3373259426;
  localparam logic [63:0] OneQ30 = 64'd1073741824;
  localparam logic [63:0] TaylorDiv [10] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420
  };

  typedef logic [7:0] wave_tbl_t [TblSize];

  // One square-root stage: radicand still to consume, partial root, remainder,
  // and the fields that ride along.
  typedef struct packed {
    logic [RadW-1:0]  rad;
    logic [RootW-1:0] root;
    logic [RemW-1:0]  rem;
    logic [15:0]      ax;
    logic [15:0]      ay;
    logic [15:0]      axy;
    logic [15:0]      ph;
    logic             last;
  } sq_stage_t;

  // sin(pi/2 * j / Qtr) in Q30.
  function automatic logic [63:0] quarter_sin(input int j);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    if (j >= Qtr) begin
      return OneQ30;
    end
    x = (PiQ30 * 64'd2 * 64'(j) + (64'd1 << (SineIdxBits - 1))) >> SineIdxBits;
    x2 = (x * x) >> 30;
    term = x;
    sum = $signed(x);
    for (int n = 1; n <= 10; n++) begin
      term = ((term * x2) >> 30) / TaylorDiv[n-1];
      if ((n % 2) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (64'(sum) > OneQ30) begin
      sum = $signed(OneQ30);
    end
    return 64'(sum);
  endfunction

  // Full-wave table of round(127 + 127*sin).
  function automatic wave_tbl_t build_wave();
    wave_tbl_t t;
    int q;
    int j;
    logic [63:0] s;
    logic [63:0] base;
    logic [63:0] v;
    base = 64'd127 * OneQ30 + (OneQ30 >> 1);
    for (int i = 0; i < TblSize; i++) begin
      q = i / Qtr;
      j = i % Qtr;
      s = ((q % 2) == 1) ? quarter_sin(Qtr - j) : quarter_sin(j);
      v = (q < 2) ? base + 64'd127 * s : base - 64'd127 * s;
      t[i] = v[37:30];
    end
    return t;
  endfunction

  localparam wave_tbl_t Wave = build_wave();

endpackage
`default_nettype wire

>>> sv/plasma_pattern_generator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipeline registers from input beat to output beat at the default widths: input, multiply,
// radicand, nine square-root stages, radial angle, table, output. Throughput: one pixel per
// cycle while in_tready is high; the square-root pipeline retires up to two root bits per
// stage. A two-entry output buffer keeps a full pipeline from losing beats.
// Reset: synchronous active low; clears valid bits, frame phase and sets phase_step to 1252.
// ----------------------------------------------------------------------------
// plasma_pattern_generator_unit
// Plasma test pattern: four table sines of x, y, x+y and radius, averaged.
// ----------------------------------------------------------------------------
module plasma_pattern_generator_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // in_tdata: pixel_x, pixel_y (lowest bits first)
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [ppg_pkg::InDataW-1:0]   in_tdata,
  input  wire logic                          in_tlast,
  // out_tdata: blue, green, red, alpha, zero pad (lowest bits first)
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [ppg_pkg::OutDataW-1:0]       out_tdata,
  output logic                               out_tlast,
  input  wire logic                          cfg_wr_en,
  input  wire logic [15:0]                   cfg_wr_data
);
  import ppg_pkg::*;

  logic en;
  logic [15:0] step_r;
  logic [15:0] phase_r;

  // Input stage.
  logic v0_r;
  logic [CoordBits-1:0] x0_r, y0_r;
  logic [15:0] ph0_r;
  logic last0_r;

  // Multiply stage.
  logic v1_r;
  logic [SqW-1:0] xx1_r, yy1_r;
  logic [15:0] ax1_r, ay1_r, axy1_r, ph1_r;
  logic last1_r;
  logic [MulW-1:0] px, py, pxy;

  // Square-root stages.
  sq_stage_t sq_r   [SqStages+1];
  sq_stage_t sq_nxt [SqStages+1];
  logic      sqv_r  [SqStages+1];

  // Radial angle stage.
  logic vr_r;
  logic [15:0] axr_r, ayr_r, axyr_r, arr_r, phr_r;
  logic lastr_r;
  logic [MulRW-1:0] pr;

  // Table stage.
  logic vw_r;
  logic [7:0] w_r [4];
  logic lastw_r;
  logic [15:0] ia, ib, ic, id;

  // Output and buffer.
  logic [9:0] wsum;
  logic [7:0] pv;
  logic [OutDataW-1:0] item;
  logic item_v;
  logic out_load;
  logic out_valid_r, skid_valid_r;
  logic [OutDataW-1:0] out_data_r, skid_data_r;
  logic out_last_r, skid_last_r;

  assign en        = !skid_valid_r;
  assign in_tready = en;

  // Configuration and frame phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= PhaseStepReset;
      phase_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        step_r <= cfg_wr_data;
      end
      if (in_tvalid && en && in_tlast) begin
        phase_r <= phase_r + step_r;
      end
    end
  end

  // Angle products.
  assign px  = MulW'(x0_r) * MulW'(KX);
  assign py  = MulW'(y0_r) * MulW'(KY);
  assign pxy = (MulW'(x0_r) + MulW'(y0_r)) * MulW'(KXY);

  // Square-root digit steps, up to two per stage.
  always_comb begin
    logic [RemW-1:0] rem2;
    logic [RemW-1:0] trial;
    sq_stage_t s;
    rem2  = '0;
    trial = '0;
    sq_nxt[0].rad  = RadW'({SumW'(xx1_r) + SumW'(yy1_r), 8'd0});
    sq_nxt[0].root = '0;
    sq_nxt[0].rem  = '0;
    sq_nxt[0].ax   = ax1_r;
    sq_nxt[0].ay   = ay1_r;
    sq_nxt[0].axy  = axy1_r;
    sq_nxt[0].ph   = ph1_r;
    sq_nxt[0].last = last1_r;
    for (int k = 1; k <= SqStages; k++) begin
      s = sq_r[k-1];
      for (int d = 0; d < 2; d++) begin
        if ((2 * (k - 1) + d) < RootW) begin
          rem2  = {s.rem[RemW-3:0], s.rad[RadW-1 -: 2]};
          trial = {s.root, 2'b01};
          if (rem2 >= trial) begin
            s.rem  = rem2 - trial;
            s.root = {s.root[RootW-2:0], 1'b1};
          end else begin
            s.rem  = rem2;
            s.root = {s.root[RootW-2:0], 1'b0};
          end
          s.rad = {s.rad[RadW-3:0], 2'b00};
        end
      end
      sq_nxt[k] = s;
    end
  end

  assign pr = MulRW'(sq_r[SqStages].root) * MulRW'(KR);

  // Table indexes with the frame phase applied.
  assign ia = axr_r + phr_r;
  assign ib = ayr_r - phr_r;
  assign ic = axyr_r - phr_r;
  assign id = arr_r - phr_r;

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      vr_r <= 1'b0;
      vw_r <= 1'b0;
      for (int k = 0; k <= SqStages; k++) begin
        sqv_r[k] <= 1'b0;
      end
    end else if (en) begin
      v0_r     <= in_tvalid;
      v1_r     <= v0_r;
      sqv_r[0] <= v1_r;
      for (int k = 1; k <= SqStages; k++) begin
        sqv_r[k] <= sqv_r[k-1];
      end
      vr_r <= sqv_r[SqStages];
      vw_r <= vr_r;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (en) begin
      x0_r    <= in_tdata[CoordBits-1:0];
      y0_r    <= in_tdata[2*CoordBits-1:CoordBits];
      ph0_r   <= phase_r;
      last0_r <= in_tlast;

      xx1_r   <= SqW'(x0_r) * SqW'(x0_r);
      yy1_r   <= SqW'(y0_r) * SqW'(y0_r);
      ax1_r   <= px[31:16];
      ay1_r   <= py[31:16];
      axy1_r  <= pxy[31:16];
      ph1_r   <= ph0_r;
      last1_r <= last0_r;

      for (int k = 0; k <= SqStages; k++) begin
        sq_r[k] <= sq_nxt[k];
      end

      axr_r   <= sq_r[SqStages].ax;
      ayr_r   <= sq_r[SqStages].ay;
      axyr_r  <= sq_r[SqStages].axy;
      arr_r   <= pr[35:20];
      phr_r   <= sq_r[SqStages].ph;
      lastr_r <= sq_r[SqStages].last;

      w_r[0]  <= Wave[ia[15 -: SineIdxBits]];
      w_r[1]  <= Wave[ib[15 -: SineIdxBits]];
      w_r[2]  <= Wave[ic[15 -: SineIdxBits]];
      w_r[3]  <= Wave[id[15 -: SineIdxBits]];
      lastw_r <= lastr_r;
    end
  end

  // Average of the four terms and output packing.
  assign wsum   = 10'(w_r[0]) + 10'(w_r[1]) + 10'(w_r[2]) + 10'(w_r[3]);
  assign pv     = wsum[9:2];
  assign item   = {1'b0, AlphaOpaque, pv, pv, pv[7:1]};
  assign item_v = en && vw_r;

  // Output register with one skid entry.
  assign out_load = !out_valid_r || out_tready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_load) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= item_v;
      end
    end else if (item_v) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= skid_valid_r ? skid_data_r : item;
      out_last_r <= skid_valid_r ? skid_last_r : lastw_r;
    end else if (item_v) begin
      skid_data_r <= item;
      skid_last_r <= lastw_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

>>> sim/tb_plasma_pattern_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_plasma_pattern_generator_unit
// Streams pixel coordinates into the plasma generator and predicts every
// output pixel with an independent table and square-root model, including
// the frame phase that advances on each end-of-frame beat.
// ----------------------------------------------------------------------------
module tb_plasma_pattern_generator_unit;

  localparam int      TblEntries  = 1024;
  localparam int      QuarterLen  = TblEntries / 4;
  localparam int      StallLimit  = 3000;
  localparam int      DrainCycles = 40;
  localparam int      StepDefault = 1252;
  localparam logic [63:0] PiFix   = 64'd3373259426;
  localparam logic [63:0] OneFix  = 64'd1073741824;
  localparam logic [63:0] ScaleX  = 64'd97652182;
  localparam logic [63:0] ScaleY  = 64'd136713055;
  localparam logic [63:0] ScaleXY = 64'd113927546;
  localparam logic [63:0] ScaleR  = 64'd170891319;

  typedef struct packed {
    logic [6:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic       frame_done;
  } pixel_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [ppg_pkg::InDataW-1:0] in_tdata;
  logic in_tlast;
  logic out_tvalid;
  logic out_tready;
  logic [ppg_pkg::OutDataW-1:0] out_tdata;
  logic out_tlast;
  logic cfg_wr_en;
  logic [15:0] cfg_wr_data;

  logic [7:0]  sine_rom [TblEntries];
  logic [15:0] cur_phase;
  logic [15:0] cur_step;
  pixel_t      pending_pixels [$];
  int          error_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_left;
  int          quiet_cycles;

  plasma_pattern_generator_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Quarter-wave sine in Q30 from an eleven-term Taylor series.
  function automatic logic [63:0] sine_q30(input int j);
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] term;
    logic signed [63:0] acc;
    if (j >= QuarterLen) begin
      return OneFix;
    end
    a = (PiFix * 64'd2 * 64'(j) + 64'd512) >> 10;
    a2 = (a * a) >> 30;
    term = a;
    acc = $signed(a);
    for (int n = 1; n <= 10; n++) begin
      term = ((term * a2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (64'(acc) > OneFix) begin
      acc = $signed(OneFix);
    end
    return 64'(acc);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] val);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > val) begin
      bitv = bitv >> 2;
    end
    while (bitv != 0) begin
      if (val >= root + bitv) begin
        val = val - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [7:0] wave_at(input logic [15:0] angle);
    return sine_rom[angle[15:6]];
  endfunction

  // Expected pixel for one coordinate at the current frame phase.
  function automatic pixel_t plasma_pixel(input logic [11:0] px, input logic [11:0] py,
                                          input logic last, input logic [15:0] ph);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] r4;
    logic [15:0] ax;
    logic [15:0] ay;
    logic [15:0] axy;
    logic [15:0] ar;
    logic [9:0]  total;
    logic [7:0]  v;
    pixel_t p;
    x = 64'(px);
    y = 64'(py);
    r4 = int_sqrt((x * x + y * y) * 64'd256);
    ax = 16'((x * ScaleX) >> 16);
    ay = 16'((y * ScaleY) >> 16);
    axy = 16'(((x + y) * ScaleXY) >> 16);
    ar = 16'((r4 * ScaleR) >> 20);
    total = 10'(wave_at(ax + ph)) + 10'(wave_at(ay - ph)) + 10'(wave_at(axy - ph))
          + 10'(wave_at(ar - ph));
    v = total[9:2];
    p.blue = v[7:1];
    p.green = v;
    p.red = v;
    p.alpha = 8'd255;
    p.frame_done = last;
    return p;
  endfunction

  // Offer one pixel beat, with random idle cycles ahead of it.
  task automatic send_pixel(input logic [11:0] px, input logic [11:0] py, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {py, px};
    in_tlast <= last;
    do begin
      @(posedge clk);
    end while (!in_tready);
    pending_pixels.push_back(plasma_pixel(px, py, last, cur_phase));
    if (last) begin
      cur_phase = cur_phase + cur_step;
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Register write, only once the pipeline is empty.
  task automatic write_step(input logic [15:0] value);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_step = value;
  endtask

  task automatic test_corners();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_pixel(12'd0, 12'd0, 1'b0);
    send_pixel(12'd4095, 12'd4095, 1'b0);
    send_pixel(12'd4095, 12'd0, 1'b1);
    send_pixel(12'd0, 12'd4095, 1'b0);
    send_pixel(12'hAAA, 12'h555, 1'b1);
    send_pixel(12'h555, 12'hAAA, 1'b0);
    send_pixel(12'd1, 12'd1, 1'b1);
    send_pixel(12'd2048, 12'd2047, 1'b1);
  endtask

  task automatic test_step_extremes();
    write_step(16'd0);
    send_pixel(12'd100, 12'd200, 1'b1);
    send_pixel(12'd100, 12'd200, 1'b1);
    write_step(16'hFFFF);
    for (int i = 0; i < 6; i++) begin
      send_pixel(12'(i * 700), 12'(4095 - i * 650), 1'b1);
    end
    write_step(16'h8000);
    send_pixel(12'd4095, 12'd4095, 1'b1);
    send_pixel(12'd4095, 12'd4095, 1'b0);
  endtask

  // Frames of random coordinates under one idle mix.
  task automatic test_random_frames(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      send_pixel(12'($urandom), 12'($urandom), $urandom_range(19) == 0);
    end
  endtask

  // Receiver holds off while the sender keeps offering beats.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 300;
    for (int i = 0; i < 60; i++) begin
      send_pixel(12'($urandom), 12'($urandom), i % 16 == 15);
    end
  endtask

  // Output checker, receiver stalls and watchdog.
  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (out_tvalid && out_tready) begin
        got = {out_tdata[6:0], out_tdata[14:7], out_tdata[22:15], out_tdata[30:23], out_tlast};
        if (pending_pixels.size() == 0) begin
          $display("%0t: unexpected pixel %h", $time, got);
          error_count++;
        end else begin
          want = pending_pixels.pop_front();
          if (got.blue != want.blue) begin
            $display("%0t: blue exp %0d got %0d", $time, want.blue, got.blue);
            error_count++;
          end
          if (got.green != want.green) begin
            $display("%0t: green exp %0d got %0d", $time, want.green, got.green);
            error_count++;
          end
          if (got.red != want.red) begin
            $display("%0t: red exp %0d got %0d", $time, want.red, got.red);
            error_count++;
          end
          if (got.alpha != want.alpha) begin
            $display("%0t: alpha exp %0d got %0d", $time, want.alpha, got.alpha);
            error_count++;
          end
          if (got.frame_done != want.frame_done) begin
            $display("%0t: frame_done exp %0d got %0d", $time, want.frame_done,
                     got.frame_done);
            error_count++;
          end
        end
      end
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    for (int i = 0; i < TblEntries; i++) begin
      logic [63:0] s;
      logic [63:0] mid;
      logic [63:0] v;
      s = ((i / QuarterLen) % 2 == 1) ? sine_q30(QuarterLen - i % QuarterLen)
                                      : sine_q30(i % QuarterLen);
      mid = 64'd127 * OneFix + (OneFix >> 1);
      v = (i / QuarterLen < 2) ? mid + 64'd127 * s : mid - 64'd127 * s;
      sine_rom[i] = v[37:30];
    end
    error_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    quiet_cycles = 0;
    cur_phase = 16'd0;
    cur_step = 16'(StepDefault);
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corners();
    test_step_extremes();
    write_step(16'(StepDefault));
    test_random_frames(400, 0, 0);
    write_step(16'($urandom));
    test_random_frames(400, 45, 0);
    write_step(16'd1);
    test_random_frames(400, 0, 45);
    write_step(16'($urandom));
    test_random_frames(400, 37, 37);
    test_backpressure();
    wait_drained();

    if (error_count == 0 && pending_pixels.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/ppg_pkg.sv
sv/plasma_pattern_generator_unit.sv
sim/tb_plasma_pattern_generator_unit.sv
